/* hdl/dtf_pkg.sv */
// dtf_pkg: character codes, widths and the power-of-ten table for the
// decimal text to fixed-point converter. no dependencies.
`default_nettype none

package dtf_pkg;

  localparam int MANT_W  = 60;   // holds up to 18 decimal digits
  localparam int CNT_W   = 5;    // digit and fraction digit counters
  localparam int VALUE_W = 64;
  localparam int FB_W    = 6;
  localparam int STEP_W  = 7;    // divider steps, up to 60 + 32

  localparam logic [FB_W-1:0] FB_MAX   = 6'd32;
  localparam logic [FB_W-1:0] FB_RESET = 6'd16;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_POINT = 8'h2e;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef logic [MANT_W-1:0] mant_t;
  typedef logic [VALUE_W-1:0] value_t;

  // 10^n for n = 0..18
  function automatic mant_t pow10(input logic [CNT_W-1:0] n);
    mant_t p;
    unique case (n)
      5'd0:    p = 60'd1;
      5'd1:    p = 60'd10;
      5'd2:    p = 60'd100;
      5'd3:    p = 60'd1000;
      5'd4:    p = 60'd10000;
      5'd5:    p = 60'd100000;
      5'd6:    p = 60'd1000000;
      5'd7:    p = 60'd10000000;
      5'd8:    p = 60'd100000000;
      5'd9:    p = 60'd1000000000;
      5'd10:   p = 60'd10000000000;
      5'd11:   p = 60'd100000000000;
      5'd12:   p = 60'd1000000000000;
      5'd13:   p = 60'd10000000000000;
      5'd14:   p = 60'd100000000000000;
      5'd15:   p = 60'd1000000000000000;
      5'd16:   p = 60'd10000000000000000;
      5'd17:   p = 60'd100000000000000000;
      5'd18:   p = 60'd1000000000000000000;
      default: p = 60'd1;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

/* hdl/decimal_text_to_fixed.sv */
// decimal_text_to_fixed: parses decimal text, one character per item, into
// a signed 64-bit fixed-point number. depends on dtf_pkg.
`default_nettype none

// channel   direction  handshake                payload
// -------   ---------  -----------------------  ---------------------------
// input     in         in_valid / in_stall      ch, start_req
// output    out        out_valid / out_stall    value, overflow, empty_res
// config    in         cfg_wr_en                cfg_wr_data (fraction_bits)
//
// whitespace, sign, digit and point items are taken without raising in_stall.
// the item that ends a number starts a restoring divider that retires one
// quotient bit per cycle: 60 + fraction_bits steps (fraction_bits clamped
// to 32), then the result is loaded, in_stall high meanwhile.
// a string with no digits skips the division steps. rst is synchronous.
// a result held by out_stall does not block input, but a finished division
// waits for it to leave before loading, with in_stall still high.

module decimal_text_to_fixed import dtf_pkg::*; #(
  parameter int MAX_DIGITS = 18
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic [7:0]         ch,
  input  wire logic               start_req,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic [VALUE_W-1:0] value,
  output      logic               overflow,
  output      logic               empty_res,
  input  wire logic               cfg_wr_en,
  input  wire logic [FB_W-1:0]    cfg_wr_data
);

  // parser phases, plus the divider phase
  localparam logic [2:0] PH_DONE = 3'd0;
  localparam logic [2:0] PH_SKIP = 3'd1;
  localparam logic [2:0] PH_INT  = 3'd2;
  localparam logic [2:0] PH_FRAC = 3'd3;
  localparam logic [2:0] PH_DIV  = 3'd4;

  localparam value_t LIMIT_POS = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam value_t LIMIT_NEG = {1'b1, {(VALUE_W-1){1'b0}}};

  logic [2:0]       phase, phase_next;
  logic             negative, negative_next;
  mant_t            mantissa, mantissa_next;   // also the dividend shift register
  logic [CNT_W-1:0] fraction_count, fraction_count_next;
  logic [CNT_W-1:0] digit_count, digit_count_next;
  logic             too_many, too_many_next;
  logic [FB_W-1:0]  frac_bits;

  // divider
  mant_t            div_p, div_p_next;         // 10^fraction_count
  mant_t            rem, rem_next;
  value_t           quo, quo_next;
  logic             q_ovf, q_ovf_next;         // a quotient bit fell off the top
  logic [STEP_W-1:0] steps, steps_next;

  logic             out_valid_next, load_out;
  value_t           value_next;
  logic             overflow_next, empty_next;

  // character classes
  logic             is_ws, is_digit, is_sign;
  logic [3:0]       dval;
  logic [2:0]       cls_phase;

  logic [FB_W-1:0]  fb;
  logic [MANT_W:0]  r_shift;
  logic             r_ge;
  value_t           limit, mag;
  logic             res_ovf;

  mant_t            mant_base;
  logic [CNT_W-1:0] dc_base, fc_base;
  logic             tm_base, neg_base;

  assign in_stall = (phase == PH_DIV);

  assign is_ws    = ((ch >= CH_TAB) && (ch <= CH_CR)) || (ch == CH_SPACE);
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
  assign dval     = 4'(ch - CH_ZERO);
  assign fb       = (frac_bits > FB_MAX) ? FB_MAX : frac_bits;

  // a new start clears the number before this character is looked at
  assign mant_base = start_req ? '0 : mantissa;
  assign dc_base   = start_req ? '0 : digit_count;
  assign fc_base   = start_req ? '0 : fraction_count;
  assign tm_base   = start_req ? 1'b0 : too_many;
  assign neg_base  = start_req ? 1'b0 : negative;

  // a non-blank, non-sign character in the skip phase is handled as integer part
  always_comb begin
    priority if (start_req || phase == PH_SKIP) begin
      cls_phase = (is_ws || is_sign) ? PH_SKIP : PH_INT;
    end else begin
      cls_phase = phase;
    end
  end

  // one restoring division step
  assign r_shift = {rem, mantissa[MANT_W-1]};
  assign r_ge    = (r_shift >= {1'b0, div_p});

  // final saturation
  assign limit   = negative ? LIMIT_NEG : LIMIT_POS;
  assign res_ovf = too_many || q_ovf || (quo > limit);
  assign mag     = res_ovf ? limit : quo;

  always_comb begin
    phase_next          = phase;
    negative_next       = negative;
    mantissa_next       = mantissa;
    fraction_count_next = fraction_count;
    digit_count_next    = digit_count;
    too_many_next       = too_many;
    div_p_next          = div_p;
    rem_next            = rem;
    quo_next            = quo;
    q_ovf_next          = q_ovf;
    steps_next          = steps;
    load_out            = 1'b0;
    value_next          = value;
    overflow_next       = overflow;
    empty_next          = empty_res;

    if (phase == PH_DIV) begin
      if (steps != '0) begin
        mantissa_next = {mantissa[MANT_W-2:0], 1'b0};
        rem_next      = r_ge ? MANT_W'(r_shift - {1'b0, div_p}) : MANT_W'(r_shift);
        quo_next      = {quo[VALUE_W-2:0], r_ge};
        q_ovf_next    = q_ovf | quo[VALUE_W-1];
        steps_next    = steps - 1'b1;
      end else if (!out_valid || !out_stall) begin
        load_out   = 1'b1;
        phase_next = PH_DONE;
        if (digit_count == '0) begin
          value_next    = '0;
          overflow_next = 1'b0;
          empty_next    = 1'b1;
        end else begin
          value_next    = negative ? (value_t'(0) - mag) : mag;
          overflow_next = res_ovf;
          empty_next    = 1'b0;
        end
      end
    end else if (in_valid && cls_phase != PH_DONE) begin
      mantissa_next       = mant_base;
      digit_count_next    = dc_base;
      fraction_count_next = fc_base;
      too_many_next       = tm_base;
      negative_next       = neg_base;
      if (cls_phase == PH_SKIP) begin
        if (is_ws) begin
          phase_next = PH_SKIP;
        end else begin
          phase_next    = PH_INT;
          negative_next = (ch == CH_MINUS);
        end
      end else if (is_digit) begin
        phase_next = cls_phase;
        if (dc_base < CNT_W'(MAX_DIGITS)) begin
          mantissa_next    = MANT_W'({mant_base, 3'b000} + {mant_base, 1'b0} + dval);
          digit_count_next = dc_base + 1'b1;
          if (cls_phase == PH_FRAC) begin
            fraction_count_next = fc_base + 1'b1;
          end
        end else begin
          too_many_next = 1'b1;
        end
      end else if (ch == CH_POINT && cls_phase == PH_INT) begin
        phase_next = PH_FRAC;
      end else begin
        // end of the number: divide mantissa * 2^fb by 10^fraction_count
        phase_next = PH_DIV;
        div_p_next = pow10(fc_base);
        rem_next   = '0;
        quo_next   = '0;
        q_ovf_next = 1'b0;
        steps_next = (dc_base == '0) ? '0 : STEP_W'(MANT_W) + STEP_W'(fb);
      end
    end
  end

  always_comb begin
    out_valid_next = out_valid && out_stall;
    if (load_out) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_DONE;
      negative       <= 1'b0;
      mantissa       <= '0;
      fraction_count <= '0;
      digit_count    <= '0;
      too_many       <= 1'b0;
      frac_bits      <= FB_RESET;
      out_valid      <= 1'b0;
      steps          <= '0;
    end else begin
      phase          <= phase_next;
      negative       <= negative_next;
      mantissa       <= mantissa_next;
      fraction_count <= fraction_count_next;
      digit_count    <= digit_count_next;
      too_many       <= too_many_next;
      out_valid      <= out_valid_next;
      steps          <= steps_next;
      if (cfg_wr_en) begin
        frac_bits <= cfg_wr_data;
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    div_p     <= div_p_next;
    rem       <= rem_next;
    quo       <= quo_next;
    q_ovf     <= q_ovf_next;
    value     <= value_next;
    overflow  <= overflow_next;
    empty_res <= empty_next;
  end

endmodule

`default_nettype wire
